// ===== design/ucmpj_pkg.sv =====
package ucmpj_pkg;

	// Iteration count of the sine/cosine unit, one pipeline stage each (stages clamped to at most 24).
	localparam int CORDIC_ITERATIONS = 16;
	localparam int ANGLE_TABLE_LEN = 24;
	localparam int CORDIC_STAGES = (CORDIC_ITERATIONS > ANGLE_TABLE_LEN) ?
		ANGLE_TABLE_LEN : CORDIC_ITERATIONS;

	// Edges from an accepted start to the edge that takes the result beat.
	localparam int LATENCY = CORDIC_STAGES + 5;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_INDEX_W-1:0] CFG_MEAN_X = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MEAN_Y = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_MEAN_HEADING = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_MEAN_SPEED = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_MEAN_TURN = 3'd4;

	localparam int ANGLE_W = 34;
	localparam logic signed [ANGLE_W-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [ANGLE_W-1:0] PI_Q30 = 34'sd3373259426;
	localparam logic signed [ANGLE_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

	// Truncated arctangent of 2^-i, radians scaled by 2^30.
	function automatic logic signed [ANGLE_W-1:0] atan_q30(input int i);
		logic signed [ANGLE_W-1:0] a;
		case (i)
			0:  a = 34'sd843314856;
			1:  a = 34'sd497837829;
			2:  a = 34'sd263043836;
			3:  a = 34'sd133525158;
			4:  a = 34'sd67021686;
			5:  a = 34'sd33543515;
			6:  a = 34'sd16775850;
			7:  a = 34'sd8388437;
			8:  a = 34'sd4194282;
			9:  a = 34'sd2097149;
			10: a = 34'sd1048575;
			11: a = 34'sd524287;
			12: a = 34'sd262143;
			13: a = 34'sd131071;
			14: a = 34'sd65535;
			15: a = 34'sd32767;
			16: a = 34'sd16383;
			17: a = 34'sd8191;
			18: a = 34'sd4095;
			19: a = 34'sd2047;
			20: a = 34'sd1023;
			21: a = 34'sd511;
			22: a = 34'sd255;
			23: a = 34'sd127;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

// ===== design/unicycle_motion_predict_jacobian_unit.sv =====
// One-step unicycle motion prediction with its Jacobian, fully pipelined: a track beat is
// taken at every rising edge where start is high (busy is tied low, so the block never
// refuses a beat). Its result is on the output ports with done high for exactly one
// cycle. Start is registered into the input stage, which folds the heading; the beat
// then passes one CORDIC stage per iteration that rotates the vector, and the unflip,
// multiply, round and sum/saturate stages, the last of which drives done. One result per
// cycle is sustained. The receiver cannot stall the pipeline, so it must take every done
// beat. Noise means are written through cfg_we/cfg_index/cfg_data; the user must write
// them only while no track is in flight, and the block itself does not enforce this.
// Indexes beyond the five registers are ignored. All means clear at reset.
module unicycle_motion_predict_jacobian_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [31:0]                  pos_x,
	input  logic signed [31:0]                  pos_y,
	input  logic signed [15:0]                  heading,
	input  logic signed [15:0]                  speed,
	input  logic signed [15:0]                  turn_rate,
	input  logic        [15:0]                  time_step,
	input  logic                                cfg_we,
	input  logic [ucmpj_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [ucmpj_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic                                done,
	output logic signed [31:0]                  next_x,
	output logic signed [31:0]                  next_y,
	output logic signed [15:0]                  next_heading,
	output logic signed [15:0]                  next_speed,
	output logic signed [15:0]                  next_turn_rate,
	output logic signed [31:0]                  jac_x_heading,
	output logic signed [15:0]                  jac_x_speed,
	output logic signed [31:0]                  jac_y_heading,
	output logic signed [15:0]                  jac_y_speed,
	output logic                                saturated
);

	localparam int N = ucmpj_pkg::CORDIC_STAGES;
	localparam int AW = ucmpj_pkg::ANGLE_W;

	// Track data that rides alongside the CORDIC until the multipliers need it.
	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [15:0] hd;
		logic signed [15:0] sp;
		logic signed [15:0] tr;
		logic        [15:0] dt;
		logic signed [31:0] vdt;   // speed * step, Q8.24
		logic signed [32:0] trdt;  // turn rate * step, Q3.29
		logic               flip;  // heading was folded by pi
	} side_t;

	function automatic logic [32:0] sat32(input logic signed [33:0] v);
		logic [32:0] r;
		if (v > 34'sh0_7FFF_FFFF) begin
			r = {1'b1, 32'h7FFF_FFFF};
		end else if (v < -34'sh0_8000_0000) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b0, v[31:0]};
		end
		return r;
	endfunction

	function automatic logic [16:0] sat16(input logic signed [18:0] v);
		logic [16:0] r;
		if (v > 19'sh0_7FFF) begin
			r = {1'b1, 16'h7FFF};
		end else if (v < -19'sh0_8000) begin
			r = {1'b1, 16'h8000};
		end else begin
			r = {1'b0, v[15:0]};
		end
		return r;
	endfunction

	// Configuration registers.
	logic signed [31:0] mean_x_q;
	logic signed [31:0] mean_y_q;
	logic signed [15:0] mean_heading_q;
	logic signed [15:0] mean_speed_q;
	logic signed [15:0] mean_turn_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_x_q       <= '0;
			mean_y_q       <= '0;
			mean_heading_q <= '0;
			mean_speed_q   <= '0;
			mean_turn_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ucmpj_pkg::CFG_MEAN_X:       mean_x_q       <= cfg_data;
				ucmpj_pkg::CFG_MEAN_Y:       mean_y_q       <= cfg_data;
				ucmpj_pkg::CFG_MEAN_HEADING: mean_heading_q <= cfg_data[15:0];
				ucmpj_pkg::CFG_MEAN_SPEED:   mean_speed_q   <= cfg_data[15:0];
				ucmpj_pkg::CFG_MEAN_TURN:    mean_turn_q    <= cfg_data[15:0];
				default: ;  // drop writes to unknown indexes
			endcase
		end
	end

	// The pipeline never stalls.
	assign busy = 1'b0;

	// ---------------- Stage 1: fold heading into [-pi/2, pi/2], form dt products.
	logic signed [AW-1:0] z_in;
	logic signed [AW-1:0] z_fold;
	logic                 flip_in;
	logic signed [16:0]   dt_in;
	logic signed [32:0]   vdt_in;
	logic signed [32:0]   trdt_in;

	always_comb begin
		z_in  = {heading[15], heading, 17'b0};
		dt_in = {1'b0, time_step};
		if (z_in > ucmpj_pkg::HALF_PI_Q30) begin
			z_fold  = z_in - ucmpj_pkg::PI_Q30;
			flip_in = 1'b1;
		end else if (z_in < -ucmpj_pkg::HALF_PI_Q30) begin
			z_fold  = z_in + ucmpj_pkg::PI_Q30;
			flip_in = 1'b1;
		end else begin
			z_fold  = z_in;
			flip_in = 1'b0;
		end
		vdt_in  = speed * dt_in;
		trdt_in = turn_rate * dt_in;
	end

	// CORDIC stages; index 0 is stage 1, index k holds the vector after k rotations.
	logic                 v_sk    [0:N];
	logic signed [AW-1:0] cx_sk   [0:N];
	logic signed [AW-1:0] cy_sk   [0:N];
	logic signed [AW-1:0] cz_sk   [0:N];
	side_t                side_sk [0:N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sk[0] <= 1'b0;
		end else begin
			v_sk[0] <= start;
		end
	end

	always_ff @(posedge clk) begin
		cx_sk[0]        <= ucmpj_pkg::CORDIC_GAIN;
		cy_sk[0]        <= '0;
		cz_sk[0]        <= z_fold;
		side_sk[0].px   <= pos_x;
		side_sk[0].py   <= pos_y;
		side_sk[0].hd   <= heading;
		side_sk[0].sp   <= speed;
		side_sk[0].tr   <= turn_rate;
		side_sk[0].dt   <= time_step;
		side_sk[0].vdt  <= vdt_in[31:0];
		side_sk[0].trdt <= trdt_in;
		side_sk[0].flip <= flip_in;
	end

	for (genvar k = 0; k < N; k++) begin : g_cordic
		localparam logic signed [AW-1:0] ANG = ucmpj_pkg::atan_q30(k);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sk[k+1] <= 1'b0;
			end else begin
				v_sk[k+1] <= v_sk[k];
			end
		end

		// Rotate toward zero residual angle; shifts are arithmetic.
		always_ff @(posedge clk) begin
			if (!cz_sk[k][AW-1]) begin
				cx_sk[k+1] <= cx_sk[k] - (cy_sk[k] >>> k);
				cy_sk[k+1] <= cy_sk[k] + (cx_sk[k] >>> k);
				cz_sk[k+1] <= cz_sk[k] - ANG;
			end else begin
				cx_sk[k+1] <= cx_sk[k] + (cy_sk[k] >>> k);
				cy_sk[k+1] <= cy_sk[k] - (cx_sk[k] >>> k);
				cz_sk[k+1] <= cz_sk[k] + ANG;
			end
			side_sk[k+1] <= side_sk[k];
		end
	end

	// ---------------- Tail stages continue the numbering after the CORDIC array.
	// Stage 2: undo the fold; cosine and sine now fit 32 bits at scale 2^30.
	logic                 v_s2;
	logic signed [31:0]   cos_s2;
	logic signed [31:0]   sin_s2;
	side_t                side_s2;
	logic signed [AW-1:0] cx_neg;
	logic signed [AW-1:0] cy_neg;

	assign cx_neg = -cx_sk[N];
	assign cy_neg = -cy_sk[N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_sk[N];
		end
	end

	always_ff @(posedge clk) begin
		cos_s2  <= side_sk[N].flip ? cx_neg[31:0] : cx_sk[N][31:0];
		sin_s2  <= side_sk[N].flip ? cy_neg[31:0] : cy_sk[N][31:0];
		side_s2 <= side_sk[N];
	end

	// Stage 3: the four trig products.
	logic               v_s3;
	logic signed [63:0] pvc_s3;   // vdt * cos
	logic signed [63:0] pvs_s3;   // vdt * sin
	logic signed [48:0] pcd_s3;   // cos * dt
	logic signed [48:0] psd_s3;   // sin * dt
	side_t              side_s3;
	logic signed [16:0] dt_s2;

	assign dt_s2 = {1'b0, side_s2.dt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		pvc_s3  <= side_s2.vdt * cos_s2;
		pvs_s3  <= side_s2.vdt * sin_s2;
		pcd_s3  <= cos_s2 * dt_s2;
		psd_s3  <= sin_s2 * dt_s2;
		side_s3 <= side_s2;
	end

	// Stage 4: round half up to each output LSB (add half, keep the upper bits).
	logic               v_s4;
	logic signed [25:0] dx_s4;
	logic signed [25:0] dy_s4;
	logic signed [26:0] jxh_s4;
	logic signed [17:0] cdt_s4;
	logic signed [17:0] sdt_s4;
	logic signed [16:0] dh_s4;
	side_t              side_s4;

	logic signed [63:0] rnd_vc;
	logic signed [63:0] rnd_vs;
	logic signed [64:0] rnd_jx;
	logic signed [48:0] rnd_cd;
	logic signed [48:0] rnd_sd;
	logic signed [32:0] rnd_dh;

	always_comb begin
		rnd_vc = pvc_s3 + 64'sd137438953472;
		rnd_vs = pvs_s3 + 64'sd137438953472;
		rnd_jx = 65'sd137438953472 - $signed({pvs_s3[63], pvs_s3});
		rnd_cd = pcd_s3 + 49'sd1073741824;
		rnd_sd = psd_s3 + 49'sd1073741824;
		rnd_dh = side_s3.trdt + 33'sd32768;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		dx_s4   <= rnd_vc[63:38];
		dy_s4   <= rnd_vs[63:38];
		jxh_s4  <= rnd_jx[64:38];
		cdt_s4  <= rnd_cd[48:31];
		sdt_s4  <= rnd_sd[48:31];
		dh_s4   <= rnd_dh[32:16];
		side_s4 <= side_s3;
	end

	// Stage 5: exact sums, then saturate each field once and merge the clip flags.
	logic [32:0] c_nx;
	logic [32:0] c_ny;
	logic [16:0] c_nh;
	logic [16:0] c_ns;
	logic [16:0] c_nt;
	logic [32:0] c_jxh;
	logic [16:0] c_jxs;
	logic [32:0] c_jyh;
	logic [16:0] c_jys;

	always_comb begin
		c_nx  = sat32(34'(side_s4.px) + 34'(dx_s4) + 34'(mean_x_q));
		c_ny  = sat32(34'(side_s4.py) + 34'(dy_s4) + 34'(mean_y_q));
		c_nh  = sat16(19'(side_s4.hd) + 19'(dh_s4) + 19'(mean_heading_q));
		c_ns  = sat16(19'(side_s4.sp) + 19'(mean_speed_q));
		c_nt  = sat16(19'(side_s4.tr) + 19'(mean_turn_q));
		c_jxh = sat32(34'(jxh_s4));
		c_jxs = sat16(19'(cdt_s4));
		c_jyh = sat32(34'(dx_s4));
		c_jys = sat16(19'(sdt_s4));
	end

	logic               v_s5;
	logic signed [31:0] nx_s5;
	logic signed [31:0] ny_s5;
	logic signed [15:0] nh_s5;
	logic signed [15:0] ns_s5;
	logic signed [15:0] nt_s5;
	logic signed [31:0] jxh_s5;
	logic signed [15:0] jxs_s5;
	logic signed [31:0] jyh_s5;
	logic signed [15:0] jys_s5;
	logic               sat_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		nx_s5  <= c_nx[31:0];
		ny_s5  <= c_ny[31:0];
		nh_s5  <= c_nh[15:0];
		ns_s5  <= c_ns[15:0];
		nt_s5  <= c_nt[15:0];
		jxh_s5 <= c_jxh[31:0];
		jxs_s5 <= c_jxs[15:0];
		jyh_s5 <= c_jyh[31:0];
		jys_s5 <= c_jys[15:0];
		sat_s5 <= c_nx[32] | c_ny[32] | c_nh[16] | c_ns[16] | c_nt[16] |
			c_jxh[32] | c_jxs[16] | c_jyh[32] | c_jys[16];
	end

	assign done           = v_s5;
	assign next_x         = nx_s5;
	assign next_y         = ny_s5;
	assign next_heading   = nh_s5;
	assign next_speed     = ns_s5;
	assign next_turn_rate = nt_s5;
	assign jac_x_heading  = jxh_s5;
	assign jac_x_speed    = jxs_s5;
	assign jac_y_heading  = jyh_s5;
	assign jac_y_speed    = jys_s5;
	assign saturated      = sat_s5;

endmodule

// ===== design/ucmpj_checker.sv =====
module ucmpj_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic        [15:0] time_step,
	input logic               done,
	input logic signed [31:0] jac_x_heading,
	input logic signed [15:0] jac_x_speed,
	input logic signed [31:0] jac_y_heading,
	input logic signed [15:0] jac_y_speed
);

	localparam int LAT = ucmpj_pkg::LATENCY;

	// The pipeline takes a beat every cycle.
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	// Every accepted beat yields a result beat on done.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("result beat missing");

	// No result beat without a matching accepted beat.
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result beat without start");

	// A zero time step zeroes every Jacobian entry of that beat.
	a_zero_step: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && time_step == 16'd0) |-> ##LAT
		(done && jac_x_heading == 32'sd0 && jac_x_speed == 16'sd0 &&
		jac_y_heading == 32'sd0 && jac_y_speed == 16'sd0))
		else $error("nonzero Jacobian for zero step");

endmodule

bind unicycle_motion_predict_jacobian_unit ucmpj_checker u_ucmpj_checker (.*);
